/* rtl/core/kfe_pkg.sv */
// kfe_pkg: beat types, KISS codes and the CRC-16/CCITT-FALSE byte update
// shared by the frame encoder modules; depends on nothing
package kfe_pkg;

  localparam logic [7:0]  KISS_FEND  = 8'hC0;
  localparam logic [7:0]  KISS_FESC  = 8'hDB;
  localparam logic [7:0]  KISS_TFEND = 8'hDC;
  localparam logic [7:0]  KISS_TFESC = 8'hDD;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  // input beat
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_payload;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_end;
    logic       frame_done;
  } out_beat_t;

  // one classified item between front and back
  typedef struct packed {
    logic [7:0]  data;
    logic        open;
    logic        last;
    logic [15:0] crc;
  } kfe_entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } kfe_qstat_t;

  // back sequencer phases
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_OPEN  = 6'b000010,
    PH_DATA  = 6'b000100,
    PH_CLO   = 6'b001000,
    PH_CHI   = 6'b010000,
    PH_CLOSE = 6'b100000
  } kfe_phase_t;

  // msb-first crc update over one byte
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/kiss_frame_encoder_crc16.sv */
// kiss_frame_encoder_crc16: top level of the KISS frame encoder with crc16
// trailer; depends on kfe_pkg, kfe_front, kfe_queue and kfe_back
//
// Usage:
//   Input channel (in_valid / in_stall / in_beat) takes one payload byte per
//   beat with last_of_payload set on the final byte of a frame. The output
//   channel (out_valid / out_stall / out_beat) gives one line byte per beat.
//   The first byte of a frame is preceded by FEND; data and crc bytes are
//   escaped; after the last byte the crc (low byte first) and a closing FEND
//   follow. run_end marks the final line byte caused by an input beat and
//   frame_done marks the closing FEND.
//   An accepted input beat is written into a queue entry and, when the queue
//   is empty, goes on to the output register. Throughput: one line byte per
//   cycle from the back sequencer while the receiver does not stall; an input
//   beat causes 1 to 8 line bytes (1 for a plain byte inside a frame, 2 for an
//   escaped one). The queue of QUEUE_DEPTH entries lets input beats keep
//   arriving while the back side works or the receiver stalls.
//   Reset: no frame open, crc at 0xFFFF, queue empty, no output beat.
//   Receiver stall: the output beat holds; the queue fills, then in_stall
//   rises until the back side drains an entry.
module kiss_frame_encoder_crc16 import kfe_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  kfe_qstat_t q_stat;
  logic       push;
  logic       pop;
  kfe_entry_t push_entry;
  kfe_entry_t pop_entry;

  // front: accept and classify
  kfe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  kfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  // back: byte sequencer and output register
  kfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

/* rtl/core/kfe_front.sv */
// kfe_front: accepts payload beats, tracks frame state and running crc,
// and pushes classified entries into the queue; depends on kfe_pkg
module kfe_front import kfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_beat_t   in_beat,
  input  kfe_qstat_t q_stat,
  output logic       push,
  output kfe_entry_t push_entry
);

  logic        inside_r, inside_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_upd;

  // accept whenever the queue has room
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;
  assign crc_upd  = crc_update(crc_r, in_beat.payload_byte);

  // classify the beat
  always_comb begin
    push_entry.data = in_beat.payload_byte;
    push_entry.open = !inside_r;
    push_entry.last = in_beat.last_of_payload;
    push_entry.crc  = crc_upd;
  end

  // frame state update
  always_comb begin
    inside_nxt = inside_r;
    crc_nxt    = crc_r;
    if (push) begin
      if (in_beat.last_of_payload) begin
        inside_nxt = 1'b0;
        crc_nxt    = CRC_INIT;
      end else begin
        inside_nxt = 1'b1;
        crc_nxt    = crc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      crc_r    <= CRC_INIT;
    end else begin
      inside_r <= inside_nxt;
      crc_r    <= crc_nxt;
    end
  end

endmodule

/* rtl/core/kfe_queue.sv */
// kfe_queue: small register fifo of classified entries between front and
// back; depends on kfe_pkg
module kfe_queue import kfe_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  kfe_entry_t push_entry,
  input  logic       pop,
  output kfe_entry_t pop_entry,
  output kfe_qstat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  kfe_entry_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.empty = (cnt_r == '0);
  assign pop_entry    = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* rtl/core/kfe_back.sv */
// kfe_back: sequences a queue entry into line bytes (fend if open, escaped
// data, escaped crc and fend if last) via an output register; uses kfe_pkg
module kfe_back import kfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  kfe_qstat_t q_stat,
  input  kfe_entry_t pop_entry,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_beat
);

  kfe_phase_t phase_r, phase_nxt;
  logic       esc_r, esc_nxt;
  kfe_entry_t ent_r, ent_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_beat_t  out_r, out_nxt;
  logic [7:0] cur;
  logic       out_free;
  logic       adv;
  logic       finish;

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // raw byte of the current phase
  always_comb begin
    case (phase_r)
      PH_CLO:  cur = ent_r.crc[7:0];
      PH_CHI:  cur = ent_r.crc[15:8];
      default: cur = ent_r.data;
    endcase
  end

  // sequencer
  always_comb begin
    phase_nxt     = phase_r;
    esc_nxt       = esc_r;
    ent_nxt       = ent_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    pop           = 1'b0;
    adv           = 1'b0;
    finish        = 1'b0;

    if (phase_r != PH_IDLE && out_free) begin
      out_valid_nxt      = 1'b1;
      out_nxt.run_end    = 1'b0;
      out_nxt.frame_done = 1'b0;
      case (phase_r)
        PH_OPEN: begin
          out_nxt.line_byte = KISS_FEND;
          phase_nxt         = PH_DATA;
        end
        PH_DATA, PH_CLO, PH_CHI: begin
          if (esc_r) begin
            out_nxt.line_byte = (cur == KISS_FEND) ? KISS_TFEND : KISS_TFESC;
            esc_nxt           = 1'b0;
            adv               = 1'b1;
          end else if (cur == KISS_FEND || cur == KISS_FESC) begin
            out_nxt.line_byte = KISS_FESC;
            esc_nxt           = 1'b1;
          end else begin
            out_nxt.line_byte = cur;
            adv               = 1'b1;
          end
        end
        PH_CLOSE: begin
          out_nxt.line_byte  = KISS_FEND;
          out_nxt.frame_done = 1'b1;
          finish             = 1'b1;
        end
        default: begin
          out_nxt.line_byte = KISS_FEND;
        end
      endcase

      // step to the next phase once a byte is fully out
      if (adv) begin
        case (phase_r)
          PH_DATA: begin
            if (ent_r.last) begin
              phase_nxt = PH_CLO;
            end else begin
              finish = 1'b1;
            end
          end
          PH_CLO:  phase_nxt = PH_CHI;
          PH_CHI:  phase_nxt = PH_CLOSE;
          default: phase_nxt = phase_r;
        endcase
      end

      if (finish) begin
        out_nxt.run_end = 1'b1;
        phase_nxt       = PH_IDLE;
      end
    end

    // load the next entry as soon as this one is done
    if (phase_nxt == PH_IDLE && !q_stat.empty) begin
      pop       = 1'b1;
      ent_nxt   = pop_entry;
      esc_nxt   = 1'b0;
      phase_nxt = pop_entry.open ? PH_OPEN : PH_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    out_r <= out_nxt;
  end

endmodule
